[src/csvt_pkg.sv]
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Word types, character codes, result kinds and error codes shared by the
// tokenizer core and the top level.
// ----------------------------------------------------------------------------
package csvt_pkg;

    // Default saturation limit for the field count.
    localparam int unsigned MAX_FIELDS_DEF = 255;

    // Character codes that steer the tokenizer.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Input modes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    // Format error codes carried on a record end.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TRAIL      = 2'd1;
    localparam logic [1:0] ERR_COUNT      = 2'd2;
    localparam logic [1:0] ERR_QUOTE_OPEN = 2'd3;

    // One input word.
    typedef struct packed {
        logic       mode;
        logic [7:0] text_byte;
    } in_t;

    // One result word.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] record_fields;
        logic [1:0] format_error;
    } out_t;

endpackage

[src/csvt_core.sv]
// ----------------------------------------------------------------------------
// CSV tokenizer core
// Holds the quote, record and field-count state and works out, for one
// input word per step, the next state and at most one result word.
// ----------------------------------------------------------------------------
module csvt_core #(
    parameter int unsigned MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  csvt_pkg::in_t  item,
    output logic           emit,
    output csvt_pkg::out_t result
);
    import csvt_pkg::*;

    // Field counts saturate at the smaller of MAX_FIELDS and 255.
    localparam logic [7:0] FIELD_CAP = 8'((MAX_FIELDS < 255) ? MAX_FIELDS : 255);

    logic       quote_open_reg, quote_open_next;
    logic       prev_quote_reg, prev_quote_next;
    logic       prev_comma_reg, prev_comma_next;
    logic       record_started_reg, record_started_next;
    logic [7:0] fields_seen_reg, fields_seen_next;
    logic [7:0] expected_reg, expected_next;

    logic [7:0] count;
    logic [1:0] record_err;

    // Field count including the field that is being closed.
    assign count = (fields_seen_reg < FIELD_CAP) ? fields_seen_reg + 8'd1 : FIELD_CAP;

    // Error for a record end; a quote left open wins, then a trailing comma.
    always_comb
    begin
        if (item.mode == MODE_END && quote_open_reg)
            record_err = ERR_QUOTE_OPEN;
        else if (prev_comma_reg)
            record_err = ERR_TRAIL;
        else if (expected_reg != 8'd0 && count != expected_reg)
            record_err = ERR_COUNT;
        else
            record_err = ERR_NONE;
    end

    // Next state and result for the word in hand.
    always_comb
    begin
        quote_open_next     = quote_open_reg;
        prev_quote_next     = prev_quote_reg;
        prev_comma_next     = prev_comma_reg;
        record_started_next = record_started_reg;
        fields_seen_next    = fields_seen_reg;
        expected_next       = expected_reg;
        emit                = 1'b0;
        result              = '0;

        if (step)
        begin
            if (item.mode == MODE_END)
            begin
                // End of input: close a pending record and return to reset.
                if (record_started_reg || quote_open_reg)
                begin
                    emit                 = 1'b1;
                    result.kind          = KIND_RECORD;
                    result.record_fields = count;
                    result.format_error  = record_err;
                end
                quote_open_next     = 1'b0;
                prev_quote_next     = 1'b0;
                prev_comma_next     = 1'b0;
                record_started_next = 1'b0;
                fields_seen_next    = 8'd0;
                expected_next       = 8'd0;
            end
            else if (quote_open_reg)
            begin
                // Inside quotes every byte but a quote is data.
                record_started_next = 1'b1;
                prev_comma_next     = 1'b0;
                if (item.text_byte == CH_QUOTE)
                begin
                    quote_open_next = 1'b0;
                    prev_quote_next = 1'b1;
                end
                else
                begin
                    emit             = 1'b1;
                    result.kind      = KIND_DATA;
                    result.data_byte = item.text_byte;
                end
            end
            else if (item.text_byte == CH_QUOTE)
            begin
                // A quote opens a section; right after a closing quote it is data.
                record_started_next = 1'b1;
                prev_comma_next     = 1'b0;
                quote_open_next     = 1'b1;
                if (prev_quote_reg)
                begin
                    prev_quote_next  = 1'b0;
                    emit             = 1'b1;
                    result.kind      = KIND_DATA;
                    result.data_byte = CH_QUOTE;
                end
            end
            else
            begin
                prev_quote_next = 1'b0;
                if (item.text_byte inside {CH_CR, CH_LF})
                begin
                    // A line break ends a record that has bytes; blank lines vanish.
                    if (record_started_reg)
                    begin
                        emit                 = 1'b1;
                        result.kind          = KIND_RECORD;
                        result.record_fields = count;
                        result.format_error  = record_err;
                        if (!prev_comma_reg && expected_reg == 8'd0)
                            expected_next = count;
                        quote_open_next     = 1'b0;
                        prev_comma_next     = 1'b0;
                        record_started_next = 1'b0;
                        fields_seen_next    = 8'd0;
                    end
                end
                else if (item.text_byte == CH_COMMA)
                begin
                    record_started_next = 1'b1;
                    fields_seen_next    = count;
                    prev_comma_next     = 1'b1;
                    emit                = 1'b1;
                    result.kind         = KIND_FIELD;
                end
                else
                begin
                    record_started_next = 1'b1;
                    prev_comma_next     = 1'b0;
                    emit                = 1'b1;
                    result.kind         = KIND_DATA;
                    result.data_byte    = item.text_byte;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_open_reg     <= 1'b0;
            prev_quote_reg     <= 1'b0;
            prev_comma_reg     <= 1'b0;
            record_started_reg <= 1'b0;
            fields_seen_reg    <= 8'd0;
            expected_reg       <= 8'd0;
        end
        else
        begin
            quote_open_reg     <= quote_open_next;
            prev_quote_reg     <= prev_quote_next;
            prev_comma_reg     <= prev_comma_next;
            record_started_reg <= record_started_next;
            fields_seen_reg    <= fields_seen_next;
            expected_reg       <= expected_next;
        end
    end

    // The running and learned counts never pass the cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        fields_seen_reg <= FIELD_CAP && expected_reg <= FIELD_CAP)
        else $error("field count above cap");

    // A closed quote that may be doubled implies the section is not open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(prev_quote_reg && quote_open_reg))
        else $error("quote open and just closed at once");

    // End of input returns every state bit to reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.mode == MODE_END |=>
            !quote_open_reg && !prev_quote_reg && !prev_comma_reg &&
            !record_started_reg && fields_seen_reg == 8'd0 && expected_reg == 8'd0)
        else $error("state not cleared after end of input");

    // A record end always reports at least one field.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.kind == KIND_RECORD |-> result.record_fields != 8'd0)
        else $error("record end with zero fields");

endmodule

[src/csv_field_record_tokenizer.sv]
// ----------------------------------------------------------------------------
// CSV field and record tokenizer
// Splits comma-separated text into field bytes, field ends and record ends.
// ----------------------------------------------------------------------------
// Takes one text word per clock and gives at most one result word for it,
// sustaining one word per cycle unless the output stalls. A word passes an
// input register, then the tokenizer state logic, then an output register.
// While the output register is empty or being taken, both registers move
// every cycle. A result held by a stalled output stops the tokenizer. The
// input register still takes one more word if it is empty, and after that
// the input stalls until the output moves. Words that produce nothing
// (quotes, blank line breaks, end of input with no pending record) are
// absorbed without an output word. The first record of a stream that a line
// break ends with no trailing comma fixes the expected field count; an
// end-of-input word resets all state, including that count.
module csv_field_record_tokenizer #(
    parameter int unsigned MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           text_valid,
    output logic           text_stall,
    input  csvt_pkg::in_t  text_word,
    output logic           token_valid,
    input  logic           token_stall,
    output csvt_pkg::out_t token_word
);
    import csvt_pkg::*;

    logic valid_a_reg;
    in_t  word_a_reg;
    logic valid_b_reg;
    out_t word_b_reg;

    logic move_b;
    logic move_a;
    logic emit;
    out_t result;

    // The output register loads when empty or being drained; the input register
    // loads when empty or when its word moves on.
    assign move_b     = !valid_b_reg || !token_stall;
    assign move_a     = !valid_a_reg || move_b;
    assign text_stall = !move_a;

    // Tokenizer state and result logic.
    csvt_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (valid_a_reg && move_b),
        .item   (word_a_reg),
        .emit   (emit),
        .result (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (move_a)
            valid_a_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (move_a && text_valid)
            word_a_reg <= text_word;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (move_b)
            valid_b_reg <= valid_a_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (move_b && valid_a_reg && emit)
            word_b_reg <= result;
    end

    assign token_valid = valid_b_reg;
    assign token_word  = word_b_reg;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer testbench
// Drives byte and end-of-input words into the tokenizer and compares every
// result word with a cycle-free model of the quote, field and record rules.
// A short table of directed words comes first, then random streams of
// records with quoted fields, blank lines and malformed records. Three idle
// patterns run in turn, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module tb;
    import csvt_pkg::*;

    localparam int unsigned FIELD_CAP =
        (MAX_FIELDS_DEF < 255) ? MAX_FIELDS_DEF : 255;
    localparam int PHASE_WORDS  = 550;
    localparam int PRESSURE_AT  = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_ROWS     = 25;

    // One directed word, with its result typed in where it is obvious.
    typedef struct packed {
        in_t  word;
        logic typed;
        logic yields;
        out_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     text_valid;
    logic     text_stall;
    in_t      text_word;
    logic     token_valid;
    logic     token_stall;
    out_t     token_word;
    logic     hold_off;

    int       send_gap_pct;
    int       recv_stall_pct;
    int       words_sent = 0;
    int       failures = 0;
    int       cycles = 0;
    out_t     tokens_due [$];
    dir_row_t dir_script [0:DIR_ROWS-1];

    // Tokenizer state as the model sees it.
    logic       in_quote;
    logic       quote_closed;
    logic       comma_last;
    logic       rec_open;
    logic [7:0] field_cnt;
    logic [7:0] learned_cnt;

    csv_field_record_tokenizer #(
        .MAX_FIELDS (MAX_FIELDS_DEF)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] count_up(input logic [7:0] v);
        return (v < FIELD_CAP) ? v + 8'd1 : 8'(FIELD_CAP);
    endfunction

    function automatic void clear_scan(input logic whole_stream);
        in_quote     = 1'b0;
        quote_closed = 1'b0;
        comma_last   = 1'b0;
        rec_open     = 1'b0;
        field_cnt    = 8'd0;
        if (whole_stream)
            learned_cnt = 8'd0;
    endfunction

    // Counts the last field and grades the record; the first clean record
    // of a stream fixes the field count.
    function automatic out_t record_end(input logic quote_left);
        logic [7:0] total;
        out_t       r;
        total = count_up(field_cnt);
        r = '{KIND_RECORD, 8'h00, total, ERR_NONE};
        if (quote_left)
            r.format_error = ERR_QUOTE_OPEN;
        else if (comma_last)
            r.format_error = ERR_TRAIL;
        else if (learned_cnt == 8'd0)
            learned_cnt = total;
        else if (total != learned_cnt)
            r.format_error = ERR_COUNT;
        return r;
    endfunction

    // Advances the model by one word; returns whether a result is due.
    function automatic logic scan_word(input in_t w, output out_t r);
        logic       hit;
        logic [7:0] c;
        hit = 1'b0;
        r   = '0;
        c   = w.text_byte;
        if (w.mode == MODE_END)
        begin
            if (rec_open || in_quote)
            begin
                hit = 1'b1;
                r   = record_end(in_quote);
            end
            clear_scan(1'b1);
        end
        else if (in_quote)
        begin
            rec_open   = 1'b1;
            comma_last = 1'b0;
            if (c == CH_QUOTE)
            begin
                in_quote     = 1'b0;
                quote_closed = 1'b1;
            end
            else
            begin
                hit = 1'b1;
                r   = '{KIND_DATA, c, 8'h00, ERR_NONE};
            end
        end
        else if (c == CH_QUOTE)
        begin
            // A quote right after a closing one is an escaped quote.
            rec_open   = 1'b1;
            comma_last = 1'b0;
            in_quote   = 1'b1;
            if (quote_closed)
            begin
                quote_closed = 1'b0;
                hit          = 1'b1;
                r            = '{KIND_DATA, CH_QUOTE, 8'h00, ERR_NONE};
            end
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            quote_closed = 1'b0;
            if (rec_open)
            begin
                hit = 1'b1;
                r   = record_end(1'b0);
                clear_scan(1'b0);
            end
        end
        else
        begin
            quote_closed = 1'b0;
            rec_open     = 1'b1;
            hit          = 1'b1;
            if (c == CH_COMMA)
            begin
                field_cnt  = count_up(field_cnt);
                comma_last = 1'b1;
                r          = '{KIND_FIELD, 8'h00, 8'h00, ERR_NONE};
            end
            else
            begin
                comma_last = 1'b0;
                r          = '{KIND_DATA, c, 8'h00, ERR_NONE};
            end
        end
        return hit;
    endfunction

    // Offers one word after a random gap and books its result once taken.
    task automatic push_text(input in_t w, input logic typed = 1'b0,
                             input logic yields = 1'b0, input out_t want = '0);
        out_t r;
        logic hit;
        while ($urandom_range(99) < send_gap_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_word  <= w;
        do
            @(posedge clk);
        while (text_stall);
        words_sent++;
        hit = scan_word(w, r);
        if (typed)
        begin
            hit = yields;
            r   = want;
        end
        if (hit)
            tokens_due = {tokens_due, r};
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_COMMA || c == CH_QUOTE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    task automatic put_char(input logic [7:0] c);
        push_text('{MODE_BYTE, c});
    endtask

    task automatic put_end();
        push_text('{MODE_END, 8'($urandom_range(255))});
    endtask

    // One field: plain, quoted, or plain text running into a quoted part.
    task automatic put_field();
        int         style;
        int         len;
        int         pick;
        logic [7:0] c;
        style = $urandom_range(99);
        len   = $urandom_range(0, 6);
        if (style < 55)
        begin
            repeat (len) put_char(plain_char());
        end
        else
        begin
            if (style >= 85)
                repeat ($urandom_range(1, 3)) put_char(plain_char());
            put_char(CH_QUOTE);
            repeat (len)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    put_char(CH_QUOTE);
                    put_char(CH_QUOTE);
                end
                else if (pick < 20)
                    put_char(CH_COMMA);
                else if (pick < 25)
                    put_char(CH_CR);
                else if (pick < 30)
                    put_char(CH_LF);
                else
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (c == CH_QUOTE);
                    put_char(c);
                end
            end
            put_char(CH_QUOTE);
            if ($urandom_range(9) == 0)
                put_char(plain_char());
        end
    endtask

    // One record with a random line ending, sometimes malformed.
    task automatic put_record(input int nfields);
        int shape;
        for (int i = 0; i < nfields; i++)
        begin
            if (i > 0)
                put_char(CH_COMMA);
            put_field();
        end
        shape = $urandom_range(99);
        if (shape < 8)
            put_char(CH_COMMA);
        if (shape >= 8 && shape < 12)
        begin
            put_char(CH_QUOTE);
            put_char(plain_char());
            put_end();
        end
        else
        begin
            case ($urandom_range(3))
                0: put_char(CH_LF);
                1: put_char(CH_CR);
                2:
                begin
                    put_char(CH_CR);
                    put_char(CH_LF);
                end
                default:
                begin
                    put_char(CH_CR);
                    put_char(CH_LF);
                    put_char(CH_LF);
                end
            endcase
        end
    endtask

    // A stream of records that mostly keep one width.
    task automatic put_stream();
        int width;
        int pick;
        width = $urandom_range(1, 5);
        repeat ($urandom_range(3, 10))
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                put_record(width);
            else if (pick < 92)
                put_record($urandom_range(1, 7));
            else
                repeat ($urandom_range(1, 8)) push_text(in_t'(9'($urandom_range(511))));
        end
        if ($urandom_range(3) != 0)
            put_end();
    endtask

    // Result side: random stalls, long hold on request, in-order checking.
    initial
    begin
        out_t want;
        token_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_valid && !token_stall)
            begin
                if (tokens_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected word: kind=%0d data=%h fields=%0d err=%0d",
                                 token_word.kind, token_word.data_byte,
                                 token_word.record_fields, token_word.format_error);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (token_word.kind != want.kind
                        || token_word.data_byte != want.data_byte
                        || token_word.record_fields != want.record_fields
                        || token_word.format_error != want.format_error)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: want %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                     want.kind, want.data_byte, want.record_fields,
                                     want.format_error, token_word.kind,
                                     token_word.data_byte, token_word.record_fields,
                                     token_word.format_error);
                    end
                end
            end
            token_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long output hold while the input side keeps offering words.
    initial
    begin
        hold_off = 1'b0;
        wait (words_sent >= PRESSURE_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        rst_n          = 1'b0;
        text_valid     = 1'b0;
        text_word      = '0;
        send_gap_pct   = 29;
        recv_stall_pct = 64;
        clear_scan(1'b1);

        // Directed words: empty end, field ends, quoting rules, every error.
        dir_script = '{
            '{'{MODE_END, 8'hFF}, 1'b1, 1'b0, '0},
            '{'{MODE_BYTE, 8'h61}, 1'b1, 1'b1, '{KIND_DATA, 8'h61, 8'h00, ERR_NONE}},
            '{'{MODE_BYTE, CH_COMMA}, 1'b1, 1'b1, '{KIND_FIELD, 8'h00, 8'h00, ERR_NONE}},
            '{'{MODE_BYTE, 8'hFF}, 1'b1, 1'b1, '{KIND_DATA, 8'hFF, 8'h00, ERR_NONE}},
            '{'{MODE_BYTE, CH_LF}, 1'b1, 1'b1, '{KIND_RECORD, 8'h00, 8'd2, ERR_NONE}},
            '{'{MODE_BYTE, CH_CR}, 1'b1, 1'b0, '0},
            '{'{MODE_BYTE, CH_QUOTE}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_COMMA}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_LF}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_QUOTE}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_QUOTE}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, 8'h62}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_QUOTE}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, 8'h00}, 1'b1, 1'b1, '{KIND_DATA, 8'h00, 8'h00, ERR_NONE}},
            '{'{MODE_BYTE, CH_CR}, 1'b1, 1'b1, '{KIND_RECORD, 8'h00, 8'd1, ERR_COUNT}},
            '{'{MODE_BYTE, CH_LF}, 1'b1, 1'b0, '0},
            '{'{MODE_BYTE, 8'h78}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_COMMA}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_CR}, 1'b1, 1'b1, '{KIND_RECORD, 8'h00, 8'd2, ERR_TRAIL}},
            '{'{MODE_BYTE, CH_COMMA}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_COMMA}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, CH_LF}, 1'b1, 1'b1, '{KIND_RECORD, 8'h00, 8'd3, ERR_TRAIL}},
            '{'{MODE_BYTE, CH_QUOTE}, 1'b0, 1'b0, '0},
            '{'{MODE_BYTE, 8'h80}, 1'b0, 1'b0, '0},
            '{'{MODE_END, 8'h00}, 1'b1, 1'b1,
              '{KIND_RECORD, 8'h00, 8'd1, ERR_QUOTE_OPEN}}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_script[i])
            push_text(dir_script[i].word, dir_script[i].typed,
                      dir_script[i].yields, dir_script[i].want);

        // One very wide record saturates the count, then a narrow one differs.
        repeat (256) put_char(CH_COMMA);
        put_char(plain_char());
        put_char(CH_LF);
        put_record(2);
        put_end();

        // Random streams under three idle patterns.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct   = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
            recv_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
            while (words_sent < (phase + 1) * PHASE_WORDS + DIR_ROWS)
                put_stream();
        end
        text_valid <= 1'b0;

        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        failures += tokens_due.size();

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
